// ===== hdl/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg
// shared types, operation and status codes, and the controller/datapath
// command and status structs of the lifo stack engine
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int WORD_W = 32;

  typedef logic [2:0] kind_t;
  typedef logic [2:0] status_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // operation kinds
  localparam kind_t KIND_PUSH = 3'd0;
  localparam kind_t KIND_LIST = 3'd1;
  localparam kind_t KIND_PEEK = 3'd2;
  localparam kind_t KIND_POP  = 3'd3;
  localparam kind_t KIND_SWAP = 3'd4;

  // result status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_SHORT    = 3'd2;
  localparam status_t ST_OVERFLOW = 3'd3;
  localparam status_t ST_HALTED   = 3'd4;

  // memory address selects
  typedef logic [1:0] asel_t;
  localparam asel_t ASEL_COUNT    = 2'd0;
  localparam asel_t ASEL_TOP      = 2'd1;
  localparam asel_t ASEL_SECOND   = 2'd2;
  localparam asel_t ASEL_IDX_NEXT = 2'd3;

  // memory write data selects
  typedef logic [1:0] dsel_t;
  localparam dsel_t DSEL_PUSH  = 2'd0;
  localparam dsel_t DSEL_RDATA = 2'd1;
  localparam dsel_t DSEL_TMP   = 2'd2;

  typedef struct packed {
    logic    mem_we;
    asel_t   waddr_sel;
    dsel_t   wdata_sel;
    logic    mem_re;
    asel_t   raddr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_halt;
    logic    tmp_ld;
    logic    idx_ld;
    logic    idx_dec;
    logic    out_ld;
    logic    out_word_rd;
    status_t out_status;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic halted;
    logic empty;
    logic full;
    logic lt2;
    logic idx_zero;
  } sts_t;

endpackage

// ===== hdl/lse_ifs.sv =====
// ----------------------------------------------------------------------------
// lse channel interfaces
// valid/ready channels for operation words and result words
// ----------------------------------------------------------------------------
interface lse_in_if;
  logic            valid;
  logic            ready;
  lse_pkg::kind_t  kind;
  lse_pkg::word_t  push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface lse_out_if;
  logic             valid;
  logic             ready;
  lse_pkg::word_t   word;
  lse_pkg::status_t status;
  logic             last;

  modport source (output valid, output word, output status, output last, input ready);
  modport sink   (input valid, input word, input status, input last, output ready);
endinterface

// ===== hdl/lse_ram.sv =====
// ----------------------------------------------------------------------------
// lse_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lse_ctrl.sv =====
// ----------------------------------------------------------------------------
// lse_ctrl
// operation sequencer: decodes each accepted word and steps the datapath
// ----------------------------------------------------------------------------
module lse_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  lse_pkg::kind_t  in_kind,
  output logic            in_ready,
  input  lse_pkg::sts_t   sts,
  output lse_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PEEK   = 3'd1;
  localparam logic [2:0] S_LIST   = 3'd2;
  localparam logic [2:0] S_SWAP_A = 3'd3;
  localparam logic [2:0] S_SWAP_B = 3'd4;
  localparam logic [2:0] S_SWAP_C = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.out_status = lse_pkg::ST_OK;
    cmd.out_last   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (sts.halted) begin
            cmd.out_ld     = 1'b1;
            cmd.out_status = lse_pkg::ST_HALTED;
          end else begin
            unique case (in_kind)
              lse_pkg::KIND_PUSH: begin
                cmd.out_ld = 1'b1;
                if (sts.full) begin
                  cmd.out_status = lse_pkg::ST_OVERFLOW;
                  cmd.set_halt   = 1'b1;
                end else begin
                  cmd.mem_we    = 1'b1;
                  cmd.waddr_sel = lse_pkg::ASEL_COUNT;
                  cmd.wdata_sel = lse_pkg::DSEL_PUSH;
                  cmd.cnt_inc   = 1'b1;
                end
              end
              lse_pkg::KIND_LIST: begin
                // empty stack lists nothing
                if (!sts.empty) begin
                  cmd.idx_ld    = 1'b1;
                  cmd.mem_re    = 1'b1;
                  cmd.raddr_sel = lse_pkg::ASEL_TOP;
                  state_nxt     = S_LIST;
                end
              end
              lse_pkg::KIND_PEEK: begin
                if (sts.empty) begin
                  cmd.out_ld     = 1'b1;
                  cmd.out_status = lse_pkg::ST_EMPTY;
                  cmd.set_halt   = 1'b1;
                end else begin
                  cmd.mem_re    = 1'b1;
                  cmd.raddr_sel = lse_pkg::ASEL_TOP;
                  state_nxt     = S_PEEK;
                end
              end
              lse_pkg::KIND_POP: begin
                cmd.out_ld = 1'b1;
                if (sts.empty) begin
                  cmd.out_status = lse_pkg::ST_EMPTY;
                  cmd.set_halt   = 1'b1;
                end else begin
                  cmd.cnt_dec = 1'b1;
                end
              end
              lse_pkg::KIND_SWAP: begin
                if (sts.lt2) begin
                  cmd.out_ld     = 1'b1;
                  cmd.out_status = lse_pkg::ST_SHORT;
                  cmd.set_halt   = 1'b1;
                end else begin
                  cmd.mem_re    = 1'b1;
                  cmd.raddr_sel = lse_pkg::ASEL_TOP;
                  state_nxt     = S_SWAP_A;
                end
              end
              default: begin
                // undefined kinds are answered ok and ignored
                cmd.out_ld = 1'b1;
              end
            endcase
          end
        end
      end
      S_PEEK: begin
        if (sts.out_free) begin
          cmd.out_ld      = 1'b1;
          cmd.out_word_rd = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          cmd.out_ld      = 1'b1;
          cmd.out_word_rd = 1'b1;
          cmd.out_last    = sts.idx_zero;
          if (sts.idx_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_dec   = 1'b1;
            cmd.mem_re    = 1'b1;
            cmd.raddr_sel = lse_pkg::ASEL_IDX_NEXT;
          end
        end
      end
      S_SWAP_A: begin
        // hold the top entry, fetch the one below
        cmd.tmp_ld    = 1'b1;
        cmd.mem_re    = 1'b1;
        cmd.raddr_sel = lse_pkg::ASEL_SECOND;
        state_nxt     = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.mem_we    = 1'b1;
        cmd.waddr_sel = lse_pkg::ASEL_TOP;
        cmd.wdata_sel = lse_pkg::DSEL_RDATA;
        state_nxt     = S_SWAP_C;
      end
      S_SWAP_C: begin
        cmd.mem_we    = 1'b1;
        cmd.waddr_sel = lse_pkg::ASEL_SECOND;
        cmd.wdata_sel = lse_pkg::DSEL_TMP;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/lse_dp.sv =====
// ----------------------------------------------------------------------------
// lse_dp
// stack datapath: entry store, entry count, halt flag, list index, swap
// holding register and the result register
// ----------------------------------------------------------------------------
module lse_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lse_pkg::cmd_t    cmd,
  input  lse_pkg::word_t   push_value,
  output lse_pkg::sts_t    sts,
  input  logic             out_ready,
  output logic             out_valid,
  output lse_pkg::word_t   out_word,
  output lse_pkg::status_t out_status,
  output logic             out_last
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              halted_r, halted_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  lse_pkg::word_t    tmp_r, tmp_nxt;
  logic              out_valid_r, out_valid_nxt;
  lse_pkg::word_t    out_word_r, out_word_nxt;
  lse_pkg::status_t  out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic [ADDR_W-1:0] top_addr, second_addr, idx_next, waddr, raddr;
  lse_pkg::word_t    wdata, rdata;
  logic              out_free;

  assign top_addr    = ADDR_W'(count_r - CNT_W'(1));
  assign second_addr = ADDR_W'(count_r - CNT_W'(2));
  assign idx_next    = idx_r - ADDR_W'(1);
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd.waddr_sel)
      lse_pkg::ASEL_COUNT:  waddr = count_r[ADDR_W-1:0];
      lse_pkg::ASEL_TOP:    waddr = top_addr;
      lse_pkg::ASEL_SECOND: waddr = second_addr;
      default:              waddr = idx_next;
    endcase
    unique case (cmd.raddr_sel)
      lse_pkg::ASEL_TOP:    raddr = top_addr;
      lse_pkg::ASEL_SECOND: raddr = second_addr;
      lse_pkg::ASEL_IDX_NEXT: raddr = idx_next;
      default:              raddr = count_r[ADDR_W-1:0];
    endcase
    unique case (cmd.wdata_sel)
      lse_pkg::DSEL_PUSH:  wdata = push_value;
      lse_pkg::DSEL_RDATA: wdata = rdata;
      lse_pkg::DSEL_TMP:   wdata = tmp_r;
      default:             wdata = push_value;
    endcase
  end

  lse_ram #(
    .WIDTH (lse_pkg::WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt      = count_r;
    halted_nxt     = halted_r || cmd.set_halt;
    idx_nxt        = idx_r;
    tmp_nxt        = tmp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.idx_ld) begin
      idx_nxt = top_addr;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_next;
    end
    if (cmd.tmp_ld) begin
      tmp_nxt = rdata;
    end
    if (cmd.out_ld) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = cmd.out_word_rd ? rdata : '0;
      out_status_nxt = cmd.out_status;
      out_last_nxt   = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    tmp_r        <= tmp_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign sts.out_free = out_free;
  assign sts.halted   = halted_r;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CNT_W'(STACK_DEPTH));
  assign sts.lt2      = (count_r < CNT_W'(2));
  assign sts.idx_zero = (idx_r == '0);

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== hdl/lifo_stack_engine_top.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_engine_top
// bounded lifo stack of signed 32-bit words driven by operation words
// ----------------------------------------------------------------------------
// usage
//   in_chan carries one operation word: kind (push, list all, peek, pop,
//   swap) and push_value. out_chan returns result words: word, status and
//   last, where last marks the final result of an operation.
//   an operation word is taken only while the sequencer is idle and the
//   result register is empty or being drained in the same cycle.
//   push, pop, undefined kinds and every error answer in the cycle after
//   the word is taken and run at one word per cycle while results drain.
//   peek answers after a registered read of the entry store.
//   swap makes two reads and two writes on the store (one read and one
//   write port), then answers with the result.
//   list all gives its entries top to bottom, one entry per cycle while
//   the receiver keeps up; an empty stack gives nothing.
//   a stalled receiver holds the result register and the sequencer waits.
//   any error halts the engine; each later word answers status halted.
//   reset (synchronous, active low) empties the stack and clears the halt;
//   the entry store itself is not cleared, nothing is read before written.
// ----------------------------------------------------------------------------
module lifo_stack_engine_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lse_in_if.sink     in_chan,
  lse_out_if.source  out_chan
);

  // command and status between sequencer and datapath
  lse_pkg::cmd_t    cmd;
  lse_pkg::sts_t    sts;

  logic             in_ready;
  logic             out_valid;
  lse_pkg::word_t   out_word;
  lse_pkg::status_t out_status;
  logic             out_last;

  // sequencer
  lse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, counters and result register
  lse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_value (in_chan.push_value),
    .sts        (sts),
    .out_ready  (out_chan.ready),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .out_status (out_status),
    .out_last   (out_last)
  );

  assign in_chan.ready   = in_ready;
  assign out_chan.valid  = out_valid;
  assign out_chan.word   = out_word;
  assign out_chan.status = out_status;
  assign out_chan.last   = out_last;

  // a word is only taken when its result has room to land
  a_accept_needs_room : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> (!out_chan.valid || out_chan.ready))
    else $error("word taken while result register blocked");

  // once halted, every result loaded reports halted
  a_halted_results : assert property (@(posedge clk) disable iff (!rst_n)
    (sts.halted && cmd.out_ld) |-> (cmd.out_status == lse_pkg::ST_HALTED))
    else $error("non-halted status issued after halt");

  // halting always comes with an error result
  a_halt_has_error : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sts.halted) |-> ($past(cmd.out_ld) && ($past(cmd.out_status) != lse_pkg::ST_OK)))
    else $error("halt without error result");

  // the result register is never reloaded while a result is stuck
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !cmd.out_ld)
    else $error("result overwritten while stalled");

endmodule

// ===== tb/sv/lifo_stack_engine_top_test.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_engine_top_test
// self-checking bench for the lifo stack engine: operation words go in over
// the input channel with random gaps, result words come back under random
// back-pressure and are compared field by field against a behavioral stack
// kept inside the bench
// ----------------------------------------------------------------------------
module lifo_stack_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;

  // result word as the engine should produce it
  typedef struct {
    lse_pkg::word_t   word;
    lse_pkg::status_t status;
    logic             last;
  } result_t;

  logic clk;
  logic rst_n;

  lse_in_if  in_chan ();
  lse_out_if out_chan ();

  lifo_stack_engine_top #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // behavioral stack, updated when an operation word is taken
  lse_pkg::word_t stack_words [DEPTH];
  int             stack_fill;
  bit             stack_halted;

  // result words the engine still owes, oldest first
  result_t owed_results [$];

  int      error_count;
  // set for the closing part of the run: no gaps and no back-pressure
  bit      quiet;

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the engine hangs
  initial begin
    #10_000_000;
    $display("lifo_stack_engine_top_test: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic void owe(lse_pkg::word_t w, lse_pkg::status_t s, logic l);
    result_t r;
    r.word   = w;
    r.status = s;
    r.last   = l;
    owed_results.push_back(r);
  endfunction

  // an error answers once and then freezes the stack for good
  function automatic void halt_with(lse_pkg::status_t s);
    stack_halted = 1'b1;
    owe('0, s, 1'b1);
  endfunction

  // works out what one taken operation word should produce
  function automatic void apply_operation(lse_pkg::kind_t k, lse_pkg::word_t v);
    lse_pkg::word_t t;
    if (stack_halted) begin
      owe('0, lse_pkg::ST_HALTED, 1'b1);
      return;
    end
    case (k)
      lse_pkg::KIND_PUSH: begin
        if (stack_fill >= DEPTH) begin
          halt_with(lse_pkg::ST_OVERFLOW);
        end else begin
          stack_words[stack_fill] = v;
          stack_fill++;
          owe('0, lse_pkg::ST_OK, 1'b1);
        end
      end
      lse_pkg::KIND_LIST: begin
        // top to bottom, nothing at all on an empty stack
        for (int i = stack_fill - 1; i >= 0; i--)
          owe(stack_words[i], lse_pkg::ST_OK, i == 0);
      end
      lse_pkg::KIND_PEEK: begin
        if (stack_fill == 0) halt_with(lse_pkg::ST_EMPTY);
        else owe(stack_words[stack_fill-1], lse_pkg::ST_OK, 1'b1);
      end
      lse_pkg::KIND_POP: begin
        if (stack_fill == 0) begin
          halt_with(lse_pkg::ST_EMPTY);
        end else begin
          stack_fill--;
          owe('0, lse_pkg::ST_OK, 1'b1);
        end
      end
      lse_pkg::KIND_SWAP: begin
        if (stack_fill < 2) begin
          halt_with(lse_pkg::ST_SHORT);
        end else begin
          t = stack_words[stack_fill-1];
          stack_words[stack_fill-1] = stack_words[stack_fill-2];
          stack_words[stack_fill-2] = t;
          owe('0, lse_pkg::ST_OK, 1'b1);
        end
      end
      // unused kinds are acknowledged and otherwise ignored
      default: owe('0, lse_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // half plain random words, half the sign and range corners
  function automatic lse_pkg::word_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offers one operation word and returns at the edge where it is taken
  task automatic send_word(lse_pkg::kind_t k, lse_pkg::word_t v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= k;
    in_chan.push_value <= v;
    do @(posedge clk); while (!in_chan.ready);
    apply_operation(k, v);
  endtask

  // sender holds off until every owed result word is back
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // well-formed operations with random content: never trips an error
  task automatic random_operations(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40 && stack_fill < DEPTH)  send_word(lse_pkg::KIND_PUSH, pick_value());
      else if (r < 40)                   send_word(lse_pkg::KIND_POP, pick_value());
      else if (r < 55 && stack_fill > 0) send_word(lse_pkg::KIND_POP, pick_value());
      else if (r < 70 && stack_fill > 0) send_word(lse_pkg::KIND_PEEK, pick_value());
      else if (r >= 70 && r < 85 && stack_fill >= 2)
        send_word(lse_pkg::KIND_SWAP, pick_value());
      else if (r >= 85 && r < 93)        send_word(lse_pkg::KIND_LIST, pick_value());
      else if (r >= 93)
        send_word(lse_pkg::kind_t'($urandom_range(5, 7)), $urandom);
      else                               send_word(lse_pkg::KIND_PUSH, pick_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver side: ready drops in random bursts of cycles
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    hold = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 3);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result word: word %0d status %0d last %0b",
               out_chan.word, out_chan.status, out_chan.last);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_chan.word !== want.word) begin
          $error("word: expected %0d, actual %0d", want.word, out_chan.word);
          error_count++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          error_count++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_chan.last);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // list on a fresh stack gives no result word, unused kinds just ack
  task automatic test_empty_stack();
    send_word(lse_pkg::KIND_LIST, '0);
    send_word(lse_pkg::kind_t'(5), 32'h5555_5555);
    send_word(lse_pkg::kind_t'(6), 32'haaaa_aaaa);
    send_word(lse_pkg::kind_t'(7), '1);
    send_word(lse_pkg::KIND_LIST, '1);
  endtask

  // every operation on the word corners
  task automatic test_corner_values();
    send_word(lse_pkg::KIND_PUSH, 32'h8000_0000);
    send_word(lse_pkg::KIND_PEEK, '0);
    send_word(lse_pkg::KIND_PUSH, 32'h7fff_ffff);
    send_word(lse_pkg::KIND_SWAP, '0);
    send_word(lse_pkg::KIND_PEEK, '0);
    send_word(lse_pkg::KIND_PUSH, '0);
    send_word(lse_pkg::KIND_PUSH, '1);
    send_word(lse_pkg::KIND_LIST, '0);
    send_word(lse_pkg::KIND_SWAP, '0);
    send_word(lse_pkg::KIND_LIST, '0);
    send_word(lse_pkg::KIND_POP, '1);
    send_word(lse_pkg::KIND_PEEK, '0);
    send_word(lse_pkg::KIND_POP, '0);
    send_word(lse_pkg::KIND_POP, '0);
    send_word(lse_pkg::KIND_PEEK, '0);
    send_word(lse_pkg::KIND_POP, '0);
  endtask

  // fill to the brim, list all of it after a full drain, then back off
  task automatic test_full_stack();
    while (stack_fill < DEPTH) send_word(lse_pkg::KIND_PUSH, $urandom);
    wait_drained();
    send_word(lse_pkg::KIND_LIST, '0);
    send_word(lse_pkg::KIND_SWAP, '0);
    send_word(lse_pkg::KIND_PEEK, '0);
    repeat (DEPTH - 3) send_word(lse_pkg::KIND_POP, '0);
    send_word(lse_pkg::KIND_LIST, '0);
  endtask

  task automatic test_random_mix();
    random_operations(40);
  endtask

  task automatic test_back_to_back();
    random_operations(20);
  endtask

  // drive into one error at random, then every kind must report halted
  task automatic test_halt();
    int goal;
    case ($urandom_range(0, 3))
      0: begin
        while (stack_fill < DEPTH) send_word(lse_pkg::KIND_PUSH, $urandom);
        send_word(lse_pkg::KIND_PUSH, $urandom);
      end
      1: begin
        while (stack_fill > 0) send_word(lse_pkg::KIND_POP, '0);
        send_word(lse_pkg::KIND_PEEK, '0);
      end
      2: begin
        while (stack_fill > 0) send_word(lse_pkg::KIND_POP, '0);
        send_word(lse_pkg::KIND_POP, '0);
      end
      default: begin
        goal = $urandom_range(0, 1);
        if (stack_fill == 0) send_word(lse_pkg::KIND_PUSH, $urandom);
        while (stack_fill > goal) send_word(lse_pkg::KIND_POP, '0);
        send_word(lse_pkg::KIND_SWAP, '0);
      end
    endcase
    for (int k = 0; k < 8; k++) send_word(lse_pkg::kind_t'(k), $urandom);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count  = 0;
    quiet        = 1'b0;
    stack_fill   = 0;
    stack_halted = 1'b0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= lse_pkg::KIND_PUSH;
    in_chan.push_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_corner_values();
    test_full_stack();
    test_random_mix();
    // closing part runs without gaps on either side
    quiet = 1'b1;
    test_back_to_back();
    test_halt();

    wait_drained();
    // let any stray word show up
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("lifo_stack_engine_top_test: done, clean");
    end else begin
      $display("lifo_stack_engine_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== lifo_stack_engine_top.f =====
hdl/lse_pkg.sv
hdl/lse_ifs.sv
hdl/lse_ram.sv
hdl/lse_ctrl.sv
hdl/lse_dp.sv
hdl/lifo_stack_engine_top.sv
tb/sv/lifo_stack_engine_top_test.sv
